FILE: hw/rtl/qfh_pkg.sv
// qfh_pkg: shared constants, types and the CORDIC angle table for the
// ENU/FLU to NED/FRD attitude converter. No dependencies.
package qfh_pkg;

  localparam int QUAT_FRAC_BITS    = 14;
  localparam int HEADING_FRAC_BITS = 6;
  localparam int ANG_FRAC_BITS     = 16;
  localparam int CORDIC_STEPS      = 17;
  localparam int CUT_BITS          = 30;
  localparam int V_W               = 40;   // branch vector component width
  localparam int FIFO_DEPTH        = 4;
  localparam int IN_W              = 64;
  localparam int OUT_W             = 80;

  typedef logic signed [V_W-1:0] vcomp_t;

  typedef struct packed {
    vcomp_t z;
    vcomp_t y;
    vcomp_t x;
    vcomp_t w;
  } qvec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic signed [26:0] atan_step(input int unsigned i);
    logic signed [26:0] a;
    case (i)
      0:       a = 27'sd2949120;
      1:       a = 27'sd1740967;
      2:       a = 27'sd919879;
      3:       a = 27'sd466945;
      4:       a = 27'sd234379;
      5:       a = 27'sd117304;
      6:       a = 27'sd58666;
      7:       a = 27'sd29335;
      8:       a = 27'sd14668;
      9:       a = 27'sd7334;
      10:      a = 27'sd3667;
      11:      a = 27'sd1833;
      12:      a = 27'sd917;
      13:      a = 27'sd458;
      14:      a = 27'sd229;
      15:      a = 27'sd115;
      16:      a = 27'sd57;
      default: a = 27'sd0;
    endcase
    return a;
  endfunction

endpackage

FILE: hw/rtl/qfh_front.sv
// qfh_front: accepts input quaternions, forms the flipped rotation matrix
// and picks the trace branch. Depends on qfh_pkg; feeds qfh_fifo.
module qfh_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [qfh_pkg::IN_W-1:0]   s_tdata,  // in_w, in_x, in_y, in_z
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  qfh_pkg::fifo_stat_t        stat,
  output logic                       push,
  output qfh_pkg::qvec_t             push_data
);

  localparam int VW = qfh_pkg::V_W;

  function automatic qfh_pkg::vcomp_t sx(input logic signed [31:0] a);
    return {{(VW-32){a[31]}}, a};
  endfunction

  logic signed [15:0] qw, qx, qy, qz;
  logic               en, acc;
  logic               vld1, vld2, vld3;
  logic signed [31:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
  qfh_pkg::vcomp_t    p0, p1, p2, p3, p4, p5, p6, p7, p8;
  qfh_pkg::vcomp_t    tr, one;
  qfh_pkg::qvec_t     v_next, v;

  assign qw = s_tdata[15:0];
  assign qx = s_tdata[31:16];
  assign qy = s_tdata[47:32];
  assign qz = s_tdata[63:48];

  assign en        = !vld3 || !stat.full;
  assign s_tready  = en;
  assign acc       = s_tvalid && en;
  assign push      = vld3 && !stat.full;
  assign push_data = v;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else if (en) begin
      vld1 <= acc;
      vld2 <= vld1;
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ww <= qw * qw;
      xx <= qx * qx;
      yy <= qy * qy;
      zz <= qz * qz;
      xy <= qx * qy;
      wz <= qw * qz;
      xz <= qx * qz;
      wy <= qw * qy;
      yz <= qy * qz;
      wx <= qw * qx;
    end
  end

  // P = Fb * R * Fw, scaled by 2^(2*frac)
  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= (sx(xy) - sx(wz)) <<< 1;
      p1 <= sx(ww) + sx(xx) - sx(yy) - sx(zz);
      p2 <= -((sx(xz) + sx(wy)) <<< 1);
      p3 <= -(sx(ww) - sx(xx) + sx(yy) - sx(zz));
      p4 <= -((sx(xy) + sx(wz)) <<< 1);
      p5 <= (sx(yz) - sx(wx)) <<< 1;
      p6 <= -((sx(yz) + sx(wx)) <<< 1);
      p7 <= -((sx(xz) - sx(wy)) <<< 1);
      p8 <= sx(ww) - sx(xx) - sx(yy) + sx(zz);
    end
  end

  assign one = qfh_pkg::vcomp_t'(1) <<< (2 * qfh_pkg::QUAT_FRAC_BITS);
  assign tr  = p0 + p4 + p8;

  always_comb begin
    if (!tr[VW-1] && tr != 0) begin
      v_next.w = tr + one;
      v_next.x = p7 - p5;
      v_next.y = p2 - p6;
      v_next.z = p3 - p1;
    end else if (p0 > p4 && p0 > p8) begin
      v_next.w = p7 - p5;
      v_next.x = one + p0 - p4 - p8;
      v_next.y = p1 + p3;
      v_next.z = p2 + p6;
    end else if (p4 > p8) begin
      v_next.w = p2 - p6;
      v_next.x = p1 + p3;
      v_next.y = one + p4 - p0 - p8;
      v_next.z = p5 + p7;
    end else begin
      v_next.w = p3 - p1;
      v_next.x = p2 + p6;
      v_next.y = p5 + p7;
      v_next.z = one + p8 - p0 - p4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v <= v_next;
    end
  end

endmodule

FILE: hw/rtl/qfh_fifo.sv
// qfh_fifo: short queue of branch vectors between front and back.
// Depends on qfh_pkg.
module qfh_fifo #(
  parameter int DEPTH = qfh_pkg::FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  qfh_pkg::qvec_t      push_data,
  input  logic                pop,
  output qfh_pkg::qvec_t      pop_data,
  output qfh_pkg::fifo_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qfh_pkg::qvec_t mem [DEPTH];
  logic [AW-1:0]  wptr, rptr;
  logic [CW-1:0]  cnt;

  assign pop_data   = mem[rptr];
  assign stat.full  = (cnt == CW'(DEPTH));
  assign stat.empty = (cnt == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty) else $error("pop from empty queue");

  a_cnt_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> cnt == $past(cnt) + 1'b1) else $error("count lost a push");

  a_cnt_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> cnt == $past(cnt) - 1'b1) else $error("count lost a pop");

endmodule

FILE: hw/rtl/qfh_back.sv
// qfh_back: cuts the branch vector, takes the norm, divides, and runs the
// CORDIC heading; one pipeline that holds as a whole on output stall.
// Depends on qfh_pkg; drains qfh_fifo.
module qfh_back (
  input  logic                      clk,
  input  logic                      rst,
  input  qfh_pkg::qvec_t            pop_data,
  input  qfh_pkg::fifo_stat_t       stat,
  output logic                      pop,
  output logic [qfh_pkg::OUT_W-1:0] m_tdata,  // out_w, out_x, out_y, out_z, heading, pad
  output logic                      m_tvalid,
  input  logic                      m_tready
);

  localparam int VW     = qfh_pkg::V_W;
  localparam int CMW    = qfh_pkg::CUT_BITS;
  localparam int QF     = qfh_pkg::QUAT_FRAC_BITS;
  localparam int NCS    = qfh_pkg::CORDIC_STEPS;
  localparam int SQ_N   = 32;
  localparam int DIV_N  = QF + 1;
  localparam int DVW    = CMW + QF + 3;
  localparam int HD_N   = 4 + NCS + 2;
  localparam int LAT_Q  = SQ_N + 1 + DIV_N;
  localparam int HD_DLY = LAT_Q - HD_N;
  localparam int T      = 4 + LAT_Q + 1;
  localparam int SH     = qfh_pkg::ANG_FRAC_BITS - qfh_pkg::HEADING_FRAC_BITS;
  localparam logic signed [26:0] ANG_FULL = 27'(360 << qfh_pkg::ANG_FRAC_BITS);
  localparam logic signed [26:0] ANG_HALF = 27'(180 << qfh_pkg::ANG_FRAC_BITS);
  localparam logic [15:0]        HD_FULL  = 16'(360 << qfh_pkg::HEADING_FRAC_BITS);

  function automatic logic [6:0] bitlen64(input logic [63:0] a);
    logic [6:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (a[i]) r = 7'(i + 1);
    end
    return r;
  endfunction

  logic         en;
  logic [T:1]   vld;

  assign en       = !vld[T] || m_tready;
  assign pop      = en && !stat.empty;
  assign m_tvalid = vld[T];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[T-1:1], pop};
    end
  end

  // stage 1: magnitudes and cut shift
  qfh_pkg::vcomp_t vin [4];
  logic [VW-1:0]   vmag [4];
  logic [VW-1:0]   vor;
  logic [6:0]      vlen;
  logic [VW-1:0]   s1_mag [4];
  logic [3:0]      s1_sgn;
  logic [3:0]      s1_sh;

  assign vin[0] = pop_data.w;
  assign vin[1] = pop_data.x;
  assign vin[2] = pop_data.y;
  assign vin[3] = pop_data.z;

  always_comb begin
    vor = '0;
    for (int k = 0; k < 4; k++) begin
      vmag[k] = vin[k][VW-1] ? VW'(-vin[k]) : VW'(vin[k]);
      vor     = vor | vmag[k];
    end
    vlen = bitlen64(64'(vor));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        s1_mag[k] <= vmag[k];
        s1_sgn[k] <= vin[k][VW-1];
      end
      s1_sh <= (vlen > 7'(CMW)) ? 4'(vlen - 7'(CMW)) : '0;
    end
  end

  // stage 2: cut vector
  logic [3:0][CMW-1:0] s2_cm;
  logic [3:0]          s2_sgn;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        s2_cm[k] <= CMW'(s1_mag[k] >> s1_sh);
      end
      s2_sgn <= s1_sgn;
    end
  end

  // stage 3: squares and cross products
  logic [2*CMW-1:0]    s3_sq [4];
  logic [2*CMW-1:0]    s3_m03, s3_m12;
  logic                s3_s03, s3_s12;
  logic [3:0][CMW-1:0] s3_cm;
  logic [3:0]          s3_sgn;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        s3_sq[k] <= s2_cm[k] * s2_cm[k];
      end
      s3_m03 <= s2_cm[0] * s2_cm[3];
      s3_m12 <= s2_cm[1] * s2_cm[2];
      s3_s03 <= s2_sgn[0] ^ s2_sgn[3];
      s3_s12 <= s2_sgn[1] ^ s2_sgn[2];
      s3_cm  <= s2_cm;
      s3_sgn <= s2_sgn;
    end
  end

  // stage 4: norm square, heading X and Y; feeds index 0 of the root chain
  logic [63:0]         rt_rem [0:SQ_N];
  logic [63:0]         rt_r   [0:SQ_N];
  logic [3:0][CMW-1:0] cm_q   [0:SQ_N];
  logic [3:0]          sg_q   [0:SQ_N];
  logic signed [63:0]  tx, t03, t12;
  logic signed [63:0]  s4_x, s4_y;

  always_comb begin
    tx  = $signed(64'(s3_sq[0])) + $signed(64'(s3_sq[1]))
        - $signed(64'(s3_sq[2])) - $signed(64'(s3_sq[3]));
    t03 = s3_s03 ? -$signed(64'(s3_m03)) : $signed(64'(s3_m03));
    t12 = s3_s12 ? -$signed(64'(s3_m12)) : $signed(64'(s3_m12));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt_rem[0] <= 64'(s3_sq[0]) + 64'(s3_sq[1]) + 64'(s3_sq[2]) + 64'(s3_sq[3]);
      rt_r[0]   <= '0;
      cm_q[0]   <= s3_cm;
      sg_q[0]   <= s3_sgn;
      s4_x      <= tx;
      s4_y      <= (t03 + t12) <<< 1;
    end
  end

  // integer square root, one result bit per stage
  for (genvar j = 0; j < SQ_N; j++) begin : g_rt
    localparam logic [63:0] BITV = 64'(1) << (2 * (SQ_N - 1 - j));
    logic [63:0] trial;
    assign trial = rt_r[j] + BITV;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rt_rem[j] >= trial) begin
          rt_rem[j+1] <= rt_rem[j] - trial;
          rt_r[j+1]   <= (rt_r[j] >> 1) + BITV;
        end else begin
          rt_rem[j+1] <= rt_rem[j];
          rt_r[j+1]   <= rt_r[j] >> 1;
        end
        cm_q[j+1] <= cm_q[j];
        sg_q[j+1] <= sg_q[j];
      end
    end
  end

  // rounded numerators, then restoring division one quotient bit per stage
  logic [3:0][DVW-1:0]   dv_rem [0:DIV_N];
  logic [3:0][DIV_N-1:0] dv_q   [0:DIV_N];
  logic [31:0]           dv_n   [0:DIV_N];
  logic [3:0]            dv_sg  [0:DIV_N];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        dv_rem[0][k] <= (DVW'(cm_q[SQ_N][k]) << QF) + DVW'(rt_r[SQ_N][31:0] >> 1);
      end
      dv_q[0]  <= '0;
      dv_n[0]  <= rt_r[SQ_N][31:0];
      dv_sg[0] <= sg_q[SQ_N];
    end
  end

  for (genvar i = 0; i < DIV_N; i++) begin : g_dv
    localparam int B = DIV_N - 1 - i;
    logic [DVW-1:0]        dsh;
    logic [3:0][DVW-1:0]   rem_next;
    logic [3:0][DIV_N-1:0] q_next;
    always_comb begin
      dsh      = DVW'(dv_n[i]) << B;
      rem_next = dv_rem[i];
      q_next   = dv_q[i];
      for (int k = 0; k < 4; k++) begin
        if (dv_rem[i][k] >= dsh) begin
          rem_next[k]    = dv_rem[i][k] - dsh;
          q_next[k][B]   = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[i+1] <= rem_next;
        dv_q[i+1]   <= q_next;
        dv_n[i+1]   <= dv_n[i];
        dv_sg[i+1]  <= dv_sg[i];
      end
    end
  end

  // heading lane: magnitudes, leading one, scale, then CORDIC
  logic [63:0]          h1_ax, h1_ay, h2_ax, h2_ay;
  logic                 h1_nx, h1_ny, h2_nx, h2_ny, h3_nx, h3_ny;
  logic [6:0]           h2_len;
  logic [CMW-1:0]       h3_ax, h3_ay;
  logic                 h3_zero;
  logic                 h4_neg;
  logic signed [33:0]   cx [0:NCS];
  logic signed [33:0]   cy [0:NCS];
  logic signed [26:0]   cz [0:NCS];
  logic                 cs_zero [0:NCS];
  logic signed [26:0]   w1_z;
  logic                 w1_zero;
  logic [15:0]          hr;
  logic [14:0]          hd_d [0:HD_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      h1_ax   <= s4_x[63] ? 64'(-s4_x) : 64'(s4_x);
      h1_ay   <= s4_y[63] ? 64'(-s4_y) : 64'(s4_y);
      h1_nx   <= s4_x[63];
      h1_ny   <= s4_y[63];
      h2_len  <= bitlen64(h1_ax | h1_ay);
      h2_ax   <= h1_ax;
      h2_ay   <= h1_ay;
      h2_nx   <= h1_nx;
      h2_ny   <= h1_ny;
      if (h2_len > 7'(CMW)) begin
        h3_ax <= CMW'(h2_ax >> (h2_len - 7'(CMW)));
        h3_ay <= CMW'(h2_ay >> (h2_len - 7'(CMW)));
      end else begin
        h3_ax <= CMW'(h2_ax << (7'(CMW) - h2_len));
        h3_ay <= CMW'(h2_ay << (7'(CMW) - h2_len));
      end
      h3_zero <= (h2_len == '0);
      h3_nx   <= h2_nx;
      h3_ny   <= h2_ny;
    end
  end

  // negative X: turn the vector half way round and start at 180 degrees
  assign h4_neg = h3_nx && (h3_ax != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]      <= $signed(34'(h3_ax));
      cy[0]      <= (h3_ny ^ h4_neg) ? -$signed(34'(h3_ay)) : $signed(34'(h3_ay));
      cz[0]      <= h4_neg ? ANG_HALF : '0;
      cs_zero[0] <= h3_zero;
    end
  end

  for (genvar i = 0; i < NCS; i++) begin : g_cordic
    logic signed [33:0] dx, dy;
    assign dx = cx[i] >>> i;
    assign dy = cy[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy[i][33]) begin
          cx[i+1] <= cx[i] + dy;
          cy[i+1] <= cy[i] - dx;
          cz[i+1] <= cz[i] + qfh_pkg::atan_step(i);
        end else begin
          cx[i+1] <= cx[i] - dy;
          cy[i+1] <= cy[i] + dx;
          cz[i+1] <= cz[i] - qfh_pkg::atan_step(i);
        end
        cs_zero[i+1] <= cs_zero[i];
      end
    end
  end

  assign hr = 16'((w1_z + 27'(1 << (SH - 1))) >>> SH);

  always_ff @(posedge clk) begin
    if (en) begin
      if (cz[NCS][26]) begin
        w1_z <= cz[NCS] + ANG_FULL;
      end else if (cz[NCS] >= ANG_FULL) begin
        w1_z <= cz[NCS] - ANG_FULL;
      end else begin
        w1_z <= cz[NCS];
      end
      w1_zero <= cs_zero[NCS];
      if (w1_zero) begin
        hd_d[0] <= '0;
      end else if (hr >= HD_FULL) begin
        hd_d[0] <= 15'(hr - HD_FULL);
      end else begin
        hd_d[0] <= 15'(hr);
      end
      for (int k = 1; k <= HD_DLY; k++) begin
        hd_d[k] <= hd_d[k-1];
      end
    end
  end

  // output register
  logic [15:0] o_q [4];
  logic [14:0] o_hd;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        if (dv_n[DIV_N] == '0) begin
          o_q[k] <= (k == 0) ? (16'(1) << QF) : '0;
        end else if (dv_sg[DIV_N][k]) begin
          o_q[k] <= -16'(dv_q[DIV_N][k]);
        end else begin
          o_q[k] <= 16'(dv_q[DIV_N][k]);
        end
      end
      o_hd <= hd_d[HD_DLY];
    end
  end

  assign m_tdata = {1'b0, o_hd, o_q[3], o_q[2], o_q[1], o_q[0]};

endmodule

FILE: hw/rtl/quat_enu_flu_to_ned_frd_heading_unit.sv
// Top level of the ENU/FLU to NED/FRD attitude converter with yaw heading.
// Depends on qfh_pkg, qfh_front, qfh_fifo, qfh_back.
//
//  channel  dir  data bits (low to high)
//  s_*      in   in_w[15:0] in_x[31:16] in_y[47:32] in_z[63:48]
//  m_*      out  out_w[15:0] out_x[31:16] out_y[47:32] out_z[63:48]
//                heading[78:64] zero[79]
//
// One item per cycle sustained while m_tready stays high. The front registers the
// products, the matrix terms and the branch vector; the back holds a 32-step square
// root and a 15-step divider, which set its depth, beside a 17-step CORDIC.
// Reset clears all valid flags and queue pointers; no clearing pass.
// An output stall holds the back pipeline; the front keeps filling the queue
// until it is full and its output register holds a vector, then s_tready drops.
module quat_enu_flu_to_ned_frd_heading_unit #(
  parameter int FIFO_DEPTH = qfh_pkg::FIFO_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [qfh_pkg::IN_W-1:0]  s_tdata,   // in_w, in_x, in_y, in_z
  input  logic                      s_tvalid,
  output logic                      s_tready,
  output logic [qfh_pkg::OUT_W-1:0] m_tdata,   // out_w, out_x, out_y, out_z, heading
  output logic                      m_tvalid,
  input  logic                      m_tready
);

  qfh_pkg::fifo_stat_t stat;
  qfh_pkg::qvec_t      push_data, pop_data;
  logic                push, pop;

  qfh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .stat      (stat),
    .push      (push),
    .push_data (push_data)
  );

  qfh_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (stat)
  );

  qfh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_data (pop_data),
    .stat     (stat),
    .pop      (pop),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

endmodule
